// ----- rtl/bsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared widths, codes and types of the balloon shape point classifier.
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int SIZE_BITS      = 20;
	localparam int POINT_BITS     = 22;
	localparam int OFFSET_BITS    = SIZE_BITS + 2;
	localparam int CFG_DATA_BITS  = OFFSET_BITS;
	localparam int CFG_INDEX_BITS = 3;
	// working width of the doubled, rotated coordinates
	localparam int IW = ((POINT_BITS > SIZE_BITS) ? POINT_BITS : SIZE_BITS) + 4;
	// tail row offset below the apex, signed
	localparam int REL_BITS  = SIZE_BITS + 3;
	// corner offsets and doubled radii
	localparam int RAD_BITS  = SIZE_BITS + 1;
	localparam int SQ_BITS   = 2 * RAD_BITS;
	localparam int EDGE_BITS = OFFSET_BITS + SIZE_BITS + 4;

	typedef logic [1:0] class_t;
	localparam class_t CLASS_OUTSIDE = 2'd0;
	localparam class_t CLASS_FRAME   = 2'd1;
	localparam class_t CLASS_INSIDE  = 2'd2;

	typedef logic [1:0] side_t;
	localparam side_t SIDE_TOP    = 2'd0;
	localparam side_t SIDE_RIGHT  = 2'd1;
	localparam side_t SIDE_BOTTOM = 2'd2;
	localparam side_t SIDE_LEFT   = 2'd3;

	typedef logic [CFG_INDEX_BITS-1:0] reg_index_t;
	localparam reg_index_t REG_BOX_WIDTH         = 3'd0;
	localparam reg_index_t REG_BOX_HEIGHT        = 3'd1;
	localparam reg_index_t REG_BORDER_SIZE       = 3'd2;
	localparam reg_index_t REG_ROUND_RADIUS      = 3'd3;
	localparam reg_index_t REG_TAIL_LEN          = 3'd4;
	localparam reg_index_t REG_TAIL_BASE         = 3'd5;
	localparam reg_index_t REG_TAIL_SIDE         = 3'd6;
	localparam reg_index_t REG_TAIL_FRAME_OFFSET = 3'd7;

	localparam logic [SIZE_BITS-1:0]   RST_BOX_WIDTH         = SIZE_BITS'(11520);
	localparam logic [SIZE_BITS-1:0]   RST_BOX_HEIGHT        = SIZE_BITS'(11520);
	localparam logic [SIZE_BITS-1:0]   RST_BORDER_SIZE       = SIZE_BITS'(256);
	localparam logic [SIZE_BITS-1:0]   RST_ROUND_RADIUS      = SIZE_BITS'(0);
	localparam logic [SIZE_BITS-1:0]   RST_TAIL_LEN          = SIZE_BITS'(1280);
	localparam logic [SIZE_BITS-1:0]   RST_TAIL_BASE         = SIZE_BITS'(2560);
	localparam side_t                  RST_TAIL_SIDE         = SIDE_TOP;
	localparam logic [OFFSET_BITS-1:0] RST_TAIL_FRAME_OFFSET = OFFSET_BITS'(362);

	typedef struct packed {
		logic [SIZE_BITS-1:0]   box_width;
		logic [SIZE_BITS-1:0]   box_height;
		logic [SIZE_BITS-1:0]   border_size;
		logic [SIZE_BITS-1:0]   round_radius;
		logic [SIZE_BITS-1:0]   tail_len;
		logic [SIZE_BITS-1:0]   tail_base;
		side_t                  tail_side;
		logic [OFFSET_BITS-1:0] tail_frame_offset;
	} cfg_t;

	typedef struct packed {
		logic outside;   // decided outside already
		logic tail_zone; // point lies in the tail's bounding strip
		logic corner;    // point lies in a corner square
		logic band;      // point lies in a straight frame band
	} flags_t;

	typedef struct packed {
		flags_t                      flags;
		logic signed [REL_BITS-1:0]  rel;   // row offset from the tail apex
		logic [SIZE_BITS-1:0]        ax;    // |x| inside the tail strip
		logic [RAD_BITS-1:0]         rx;    // corner offsets
		logic [RAD_BITS-1:0]         ry;
	} front_t;

endpackage

// ----- rtl/bsp_front.sv -----
// ----------------------------------------------------------------------------
// bsp_front
// Rotates the point so the tail is on top, doubles it about the body center
// and derives the region flags and multiplier operands.
// ----------------------------------------------------------------------------
module bsp_front (
	input  logic signed [bsp_pkg::POINT_BITS-1:0] point_x,
	input  logic signed [bsp_pkg::POINT_BITS-1:0] point_y,
	input  bsp_pkg::cfg_t                         cfg,
	output bsp_pkg::front_t                       front
);
	import bsp_pkg::*;

	logic signed [IW-1:0] px2, py2, bw, bh, ft2, th2, cr2, tw;
	logic signed [IW-1:0] nx, ny, w, h, ax, ay, rx, ry;
	logic                 tail_en;

	always_comb begin
		px2 = {{(IW-POINT_BITS-1){point_x[POINT_BITS-1]}}, point_x, 1'b0};
		py2 = {{(IW-POINT_BITS-1){point_y[POINT_BITS-1]}}, point_y, 1'b0};
		bw  = $signed({{(IW-SIZE_BITS){1'b0}}, cfg.box_width});
		bh  = $signed({{(IW-SIZE_BITS){1'b0}}, cfg.box_height});
		ft2 = $signed({{(IW-SIZE_BITS-1){1'b0}}, cfg.border_size, 1'b0});
		th2 = $signed({{(IW-SIZE_BITS-1){1'b0}}, cfg.tail_len, 1'b0});
		cr2 = $signed({{(IW-SIZE_BITS-1){1'b0}}, cfg.round_radius, 1'b0});
		tw  = $signed({{(IW-SIZE_BITS){1'b0}}, cfg.tail_base});

		case (cfg.tail_side)
			SIDE_TOP: begin
				nx = bw - px2; ny = bh - py2; w = bw; h = bh;
			end
			SIDE_RIGHT: begin
				nx = bh - py2; ny = px2 - bw; w = bh; h = bw;
			end
			SIDE_BOTTOM: begin
				nx = px2 - bw; ny = py2 - bh; w = bw; h = bh;
			end
			default: begin
				nx = py2 - bh; ny = bw - px2; w = bh; h = bw;
			end
		endcase

		ax = (nx < 0) ? -nx : nx;
		ay = (ny < 0) ? -ny : ny;

		tail_en = (|cfg.tail_len) && (|cfg.tail_base);
		front.flags.tail_zone = tail_en && (ax < tw) && (ny > h - ft2) && (ny < h + th2);
		front.flags.outside   = (ax > w) || (!front.flags.tail_zone && (ay > h));

		rx = ax - (w - cr2);
		ry = ay - (h - cr2);
		front.flags.corner = (|cfg.round_radius) && (rx > 0) && (ry > 0);
		front.flags.band   = (ax > w - ft2) || (ay > h - ft2);

		front.rel = REL_BITS'(ny - h - th2);
		front.ax  = ax[SIZE_BITS-1:0];
		front.rx  = rx[RAD_BITS-1:0];
		front.ry  = ry[RAD_BITS-1:0];
	end

endmodule

// ----- rtl/balloon_shape_point_classifier.sv -----
// ----------------------------------------------------------------------------
// balloon_shape_point_classifier
// Classifies a sample point as outside, frame or inside a rounded speech
// balloon with a triangular tail on one side.
// ----------------------------------------------------------------------------
// stages: the point passes four register stages (input, rotated geometry,
//   products, result) with one multiplier level
// throughput: one point per cycle while the class side accepts results
// reset: clears all stage valids and loads the default balloon geometry
// ----------------------------------------------------------------------------
module balloon_shape_point_classifier (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// configuration write port
	input  logic                                      cfg_we,
	input  logic [bsp_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [bsp_pkg::CFG_DATA_BITS-1:0]         cfg_data,
	// point channel
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [bsp_pkg::POINT_BITS-1:0]     point_x,
	input  logic signed [bsp_pkg::POINT_BITS-1:0]     point_y,
	// class channel
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [1:0]                                pixel_class
);
	import bsp_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_width         <= RST_BOX_WIDTH;
			cfg_q.box_height        <= RST_BOX_HEIGHT;
			cfg_q.border_size       <= RST_BORDER_SIZE;
			cfg_q.round_radius      <= RST_ROUND_RADIUS;
			cfg_q.tail_len          <= RST_TAIL_LEN;
			cfg_q.tail_base         <= RST_TAIL_BASE;
			cfg_q.tail_side         <= RST_TAIL_SIDE;
			cfg_q.tail_frame_offset <= RST_TAIL_FRAME_OFFSET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_WIDTH:         cfg_q.box_width         <= cfg_data[SIZE_BITS-1:0];
				REG_BOX_HEIGHT:        cfg_q.box_height        <= cfg_data[SIZE_BITS-1:0];
				REG_BORDER_SIZE:       cfg_q.border_size       <= cfg_data[SIZE_BITS-1:0];
				REG_ROUND_RADIUS:      cfg_q.round_radius      <= cfg_data[SIZE_BITS-1:0];
				REG_TAIL_LEN:          cfg_q.tail_len          <= cfg_data[SIZE_BITS-1:0];
				REG_TAIL_BASE:         cfg_q.tail_base         <= cfg_data[SIZE_BITS-1:0];
				REG_TAIL_SIDE:         cfg_q.tail_side         <= cfg_data[1:0];
				REG_TAIL_FRAME_OFFSET: cfg_q.tail_frame_offset <= cfg_data[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when it is empty or its successor moves on,
	// so bubbles collapse and input keeps flowing while a result waits, until the stages fill
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en_s1, en_s2, en_s3, en_out;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= in_valid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_out) out_valid_q <= v_s3;
		end
	end

	// stage 1: input register
	logic signed [POINT_BITS-1:0] px_s1, py_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			px_s1 <= point_x;
			py_s1 <= point_y;
		end
	end

	// stage 2: rotated geometry, region flags and multiplier operands
	front_t front_c, front_s2;

	bsp_front u_front (
		.point_x (px_s1),
		.point_y (py_s1),
		.cfg     (cfg_q),
		.front   (front_c)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) front_s2 <= front_c;
	end

	// stage 3: all products, one multiplier level
	// inner corner radius may be negative when the frame is thick; only its
	// square matters, so its magnitude is used
	logic signed [SIZE_BITS+1:0]           rad_diff;
	logic [SIZE_BITS-1:0]                  rad_diff_abs;
	logic [RAD_BITS-1:0]                   inner2, outer2;
	logic signed [REL_BITS+SIZE_BITS:0]    rel_tw_c, rel_tw_s3;
	logic [2*SIZE_BITS-1:0]                th_ax_c, th_ax_s3;
	logic [OFFSET_BITS+SIZE_BITS-1:0]      off_tw_c, off_tw_s3;
	logic [SQ_BITS-1:0]                    rx_sq_c, ry_sq_c, outer_sq_c, inner_sq_c;
	logic [SQ_BITS-1:0]                    rx_sq_s3, ry_sq_s3, outer_sq_s3, inner_sq_s3;
	flags_t                                flags_s3;

	always_comb begin
		rad_diff     = $signed({2'b00, cfg_q.round_radius})
		             - $signed({2'b00, cfg_q.border_size});
		rad_diff_abs = (rad_diff < 0) ? SIZE_BITS'(-rad_diff) : SIZE_BITS'(rad_diff);
		inner2       = {rad_diff_abs, 1'b0};
		outer2       = {cfg_q.round_radius, 1'b0};
		rel_tw_c     = front_s2.rel * $signed({1'b0, cfg_q.tail_base});
		th_ax_c      = cfg_q.tail_len * front_s2.ax;
		off_tw_c     = cfg_q.tail_frame_offset * cfg_q.tail_base;
		rx_sq_c      = front_s2.rx * front_s2.rx;
		ry_sq_c      = front_s2.ry * front_s2.ry;
		outer_sq_c   = outer2 * outer2;
		inner_sq_c   = inner2 * inner2;
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			flags_s3    <= front_s2.flags;
			rel_tw_s3   <= rel_tw_c;
			th_ax_s3    <= th_ax_c;
			off_tw_s3   <= off_tw_c;
			rx_sq_s3    <= rx_sq_c;
			ry_sq_s3    <= ry_sq_c;
			outer_sq_s3 <= outer_sq_c;
			inner_sq_s3 <= inner_sq_c;
		end
	end

	// stage 4: final compares into the result register
	logic signed [EDGE_BITS-1:0] tail_edge, tail_inner;
	logic [SQ_BITS:0]            rsq;
	class_t                      class_c, class_q;

	always_comb begin
		// sloped tail edge by cross product, offset edge for the frame
		tail_edge  = EDGE_BITS'(rel_tw_s3) + $signed(EDGE_BITS'({th_ax_s3, 1'b0}));
		tail_inner = tail_edge + $signed(EDGE_BITS'({off_tw_s3, 1'b0}));
		rsq        = {1'b0, rx_sq_s3} + {1'b0, ry_sq_s3};

		if (flags_s3.outside) begin
			class_c = CLASS_OUTSIDE;
		end else if (flags_s3.tail_zone) begin
			if (tail_edge > 0)
				class_c = CLASS_OUTSIDE;
			else if (tail_inner < 0)
				class_c = CLASS_INSIDE;
			else
				class_c = CLASS_FRAME;
		end else if (flags_s3.corner) begin
			if (rsq > {1'b0, outer_sq_s3})
				class_c = CLASS_OUTSIDE;
			else if (rsq < {1'b0, inner_sq_s3})
				class_c = CLASS_INSIDE;
			else
				class_c = CLASS_FRAME;
		end else if (flags_s3.band) begin
			class_c = CLASS_FRAME;
		end else begin
			class_c = CLASS_INSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) class_q <= class_c;
	end

	assign out_valid   = out_valid_q;
	assign pixel_class = class_q;

endmodule

// ----- test/tb_balloon_shape_point_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_balloon_shape_point_classifier
// Drives sample points into the balloon classifier and checks every class.
// A shadow of the balloon registers feeds a behavioral classifier. Each point
// transfer queues its expected class, and each class transfer is compared
// against the oldest entry. Directed shapes come first, then random balloons
// with random points, under random gaps on the point side and random stalls
// on the class side.
// ----------------------------------------------------------------------------
module tb_balloon_shape_point_classifier;
	import bsp_pkg::*;

	typedef logic signed [POINT_BITS-1:0] point_t;
	typedef logic [CFG_DATA_BITS-1:0]     word_t;

	// one queued point with the class the shadow geometry gives it
	typedef struct {
		point_t x;
		point_t y;
		class_t cls;
	} class_entry_t;

	// cycles to let pass after the last class has come back
	localparam int SETTLE_CYCLES = 8;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	reg_index_t cfg_index = REG_BOX_WIDTH;
	word_t      cfg_data  = '0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	point_t     point_x   = '0;
	point_t     point_y   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	class_t     pixel_class;

	// shadow copy of the balloon registers
	cfg_t balloon_cfg;
	// classes still owed by the block, oldest first
	class_entry_t pending_classes[$];
	int  errors = 0;
	// no gaps and no stalls while set
	bit  quiet = 1'b0;
	int  ready_hold = 0;

	balloon_shape_point_classifier i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_class(pixel_class)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// behavioral classifier, all in 64-bit signed arithmetic so nothing wraps
	function automatic class_t classify_point(point_t px_in, point_t py_in, cfg_t c);
		longint bw, bh, ft, cr, th, tw, off, px, py;
		longint nx, ny, w, h, ax, ay, rel, slope, rx, ry, rsq, inner;
		bw  = longint'(c.box_width);
		bh  = longint'(c.box_height);
		ft  = longint'(c.border_size);
		cr  = longint'(c.round_radius);
		th  = longint'(c.tail_len);
		tw  = longint'(c.tail_base);
		off = longint'(c.tail_frame_offset);
		px  = longint'(px_in);
		py  = longint'(py_in);
		// turn the point so the tail is on top, doubled about the body center
		case (c.tail_side)
			SIDE_TOP: begin
				nx = bw - 2 * px; ny = bh - 2 * py; w = bw; h = bh;
			end
			SIDE_RIGHT: begin
				nx = bh - 2 * py; ny = 2 * px - bw; w = bh; h = bw;
			end
			SIDE_BOTTOM: begin
				nx = 2 * px - bw; ny = 2 * py - bh; w = bw; h = bh;
			end
			default: begin
				nx = 2 * py - bh; ny = bw - 2 * px; w = bh; h = bw;
			end
		endcase
		ax = (nx < 0) ? -nx : nx;
		if (ax > w)
			return CLASS_OUTSIDE;
		// tail strip: sloped edges tested by cross products
		if (th > 0 && tw > 0 && ax < tw && ny > h - 2 * ft && ny < h + 2 * th) begin
			rel   = ny - h - 2 * th;
			slope = rel * tw + 2 * th * ax;
			if (slope > 0)
				return CLASS_OUTSIDE;
			if (slope + 2 * off * tw < 0)
				return CLASS_INSIDE;
			return CLASS_FRAME;
		end
		ay = (ny < 0) ? -ny : ny;
		if (ay > h)
			return CLASS_OUTSIDE;
		// corner circles, a thick frame gives a negative inner radius
		if (cr > 0) begin
			rx = ax - (w - 2 * cr);
			ry = ay - (h - 2 * cr);
			if (rx > 0 && ry > 0) begin
				rsq   = rx * rx + ry * ry;
				inner = 2 * (cr - ft);
				if (rsq > 4 * cr * cr)
					return CLASS_OUTSIDE;
				if (rsq < inner * inner)
					return CLASS_INSIDE;
				return CLASS_FRAME;
			end
		end
		// straight frame bands
		if (ax > w - 2 * ft || ay > h - 2 * ft)
			return CLASS_FRAME;
		return CLASS_INSIDE;
	endfunction

	// half with no gap, most of the rest short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// class side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_hold = 0;
		end else if (quiet) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 1) == 1) begin
			out_ready <= 1'b1;
			ready_hold = $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b0;
			ready_hold = pick_gap();
		end
	end

	// queue a class on each point transfer, check it on each class transfer
	always @(posedge clk) begin
		class_entry_t owed;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				owed.x   = point_x;
				owed.y   = point_y;
				owed.cls = classify_point(point_x, point_y, balloon_cfg);
				pending_classes = {pending_classes, owed};
			end
			if (out_valid && out_ready) begin
				if (pending_classes.size() == 0) begin
					$display("%0t: class transfer with none owed, expected none, actual %0d",
						$time, pixel_class);
					errors++;
				end else begin
					owed = pending_classes.pop_front();
					if (pixel_class !== owed.cls) begin
						$display("%0t: pixel_class for point (%0d,%0d), expected %0d, actual %0d",
							$time, owed.x, owed.y, owed.cls, pixel_class);
						errors++;
					end
				end
			end
		end
	end

	// wait until every owed class has come back and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_classes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_we high, the caller lowers it after the last write
	task automatic write_reg(reg_index_t idx, word_t value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		// the shadow keeps only the register's own width
		case (idx)
			REG_BOX_WIDTH:         balloon_cfg.box_width         = value[SIZE_BITS-1:0];
			REG_BOX_HEIGHT:        balloon_cfg.box_height        = value[SIZE_BITS-1:0];
			REG_BORDER_SIZE:       balloon_cfg.border_size       = value[SIZE_BITS-1:0];
			REG_ROUND_RADIUS:      balloon_cfg.round_radius      = value[SIZE_BITS-1:0];
			REG_TAIL_LEN:          balloon_cfg.tail_len          = value[SIZE_BITS-1:0];
			REG_TAIL_BASE:         balloon_cfg.tail_base         = value[SIZE_BITS-1:0];
			REG_TAIL_SIDE:         balloon_cfg.tail_side         = value[1:0];
			REG_TAIL_FRAME_OFFSET: balloon_cfg.tail_frame_offset = value[OFFSET_BITS-1:0];
			default: ;
		endcase
	endtask

	// reprogram the whole balloon once the block has gone idle
	task automatic program_balloon(word_t bw, word_t bh, word_t ft, word_t cr,
			word_t th, word_t tw, word_t side, word_t off);
		settle();
		write_reg(REG_BOX_WIDTH, bw);
		write_reg(REG_BOX_HEIGHT, bh);
		write_reg(REG_BORDER_SIZE, ft);
		write_reg(REG_ROUND_RADIUS, cr);
		write_reg(REG_TAIL_LEN, th);
		write_reg(REG_TAIL_BASE, tw);
		write_reg(REG_TAIL_SIDE, side);
		write_reg(REG_TAIL_FRAME_OFFSET, off);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one point transfer, preceded by a random gap
	task automatic send_point(point_t x, point_t y);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x  <= x;
		point_y  <= y;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// random bits above a size register's width, they must be dropped
	function automatic word_t with_junk(longint v);
		return word_t'(v) | (word_t'($urandom_range(0, 3)) << SIZE_BITS);
	endfunction

	// coordinate near an interesting line of the current balloon
	function automatic point_t pick_coord();
		longint bw, bh, th, tw, cr, ft, a, span, jitter;
		bw = longint'(balloon_cfg.box_width);
		bh = longint'(balloon_cfg.box_height);
		th = longint'(balloon_cfg.tail_len);
		tw = longint'(balloon_cfg.tail_base);
		cr = longint'(balloon_cfg.round_radius);
		ft = longint'(balloon_cfg.border_size);
		if ($urandom_range(0, 9) < 4) begin
			// anywhere over the balloon and its tail, on any side
			span = ((bw > bh) ? bw : bh) + 2 * th + 32;
			a    = longint'($urandom_range(0, span)) - th - 16;
		end else begin
			case ($urandom_range(0, 13))
				0:  a = 0;
				1:  a = bw;
				2:  a = bh;
				3:  a = bw / 2;
				4:  a = bh / 2;
				5:  a = cr;
				6:  a = bw - cr;
				7:  a = bh - cr;
				8:  a = ft;
				9:  a = bw - ft;
				10: a = bw / 2 - tw / 2;
				11: a = bh / 2 + tw / 2;
				12: a = -th;
				default: a = bw + th;
			endcase
			jitter = ($urandom_range(0, 2) == 0) ? 300 : 8;
			a = a + longint'($urandom_range(0, 2 * jitter)) - jitter;
		end
		if (a > 2097151)
			a = 2097151;
		if (a < -2097152)
			a = -2097152;
		return point_t'(a);
	endfunction

	task automatic send_random_point();
		// a share of points anywhere in the coordinate range
		if ($urandom_range(0, 9) == 0)
			send_point(point_t'($urandom), point_t'($urandom));
		else
			send_point(pick_coord(), pick_coord());
	endtask

	// random balloon, mostly small so random points land near its edges
	task automatic roll_balloon();
		longint bw, bh, ft, cr, th, tw, off;
		int     side;
		real    ratio;
		bw = $urandom_range(64, 16384);
		bh = $urandom_range(64, 16384);
		ft = $urandom_range(0, 1023);
		cr = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, ((bw < bh) ? bw : bh) / 2);
		th = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 4096);
		tw = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, (bw > bh) ? bw : bh);
		side = $urandom_range(0, 3);
		if (tw == 0) begin
			off = ft;
		end else begin
			ratio = 2.0 * th / tw;
			off   = $rtoi(ft * $sqrt(1.0 + ratio * ratio) + 0.5);
		end
		// sometimes an offset that does not match the tail at all
		if ($urandom_range(0, 4) == 0 || off > 4194303)
			off = $urandom_range(0, 4194303);
		program_balloon(with_junk(bw), with_junk(bh), with_junk(ft), with_junk(cr),
			with_junk(th), with_junk(tw), word_t'(($urandom & ~3) | side), word_t'(off));
	endtask

	// default square balloon with its top tail, straight from reset
	task automatic test_reset_geometry();
		send_point(0, 0);
		send_point(5760, 5760);
		send_point(5760, -640);
		send_point(5760, -1279);
		send_point(5760, -1281);
		send_point(-2097152, -2097152);
		send_point(2097151, 2097151);
		send_point(2097151, -2097152);
		send_point(-2097152, 2097151);
		// right edge exactly on the body, then one past it
		send_point(11520, 5760);
		send_point(11521, 5760);
	endtask

	// thick frame, disabled tails and all-zero sizes
	task automatic test_special_shapes();
		// frame thicker than the corner radius, no tail
		program_balloon(4096, 4096, 600, 400, 0, 2560, SIDE_TOP, 362);
		send_point(100, 100);
		send_point(200, 200);
		send_point(2048, 2048);
		// tail of zero width is no tail
		program_balloon(4096, 4096, 64, 256, 1024, 0, SIDE_TOP, 64);
		send_point(2048, -100);
		// degenerate balloon
		program_balloon(0, 0, 0, 0, 0, 0, SIDE_TOP, 0);
		send_point(0, 0);
	endtask

	// tail on each side, the top one with an offset that fits nothing
	task automatic test_tail_sides();
		for (int s = 0; s < 4; s++) begin
			program_balloon(6000, 3000, 128, 300, 800, 1600, word_t'(s),
				(s == 0) ? 50000 : 181);
			case (side_t'(s))
				SIDE_TOP:    send_point(3000, -400);
				SIDE_RIGHT:  send_point(6400, 1500);
				SIDE_BOTTOM: send_point(3000, 3400);
				default:     send_point(-400, 1500);
			endcase
			send_point(3000, 1500);
		end
	endtask

	task automatic test_random_balloons();
		for (int phase = 0; phase < 9; phase++) begin
			roll_balloon();
			quiet = (phase == 1) || ($urandom_range(0, 4) == 0);
			for (int n = 0; n < 130; n++) begin
				// hold the points back until every class has returned
				if (phase == 4 && n == 65)
					settle();
				send_random_point();
			end
			quiet = 1'b0;
		end
	endtask

	// every register at its top value with junk above, then all cleared
	task automatic test_extreme_registers();
		program_balloon('1, '1, '1, '1, '1, '1, '1, '1);
		repeat (80) send_random_point();
		program_balloon(0, 0, 0, 0, 0, 0, 0, 0);
		repeat (80) send_random_point();
	endtask

	initial begin
		balloon_cfg.box_width         = RST_BOX_WIDTH;
		balloon_cfg.box_height        = RST_BOX_HEIGHT;
		balloon_cfg.border_size       = RST_BORDER_SIZE;
		balloon_cfg.round_radius      = RST_ROUND_RADIUS;
		balloon_cfg.tail_len          = RST_TAIL_LEN;
		balloon_cfg.tail_base         = RST_TAIL_BASE;
		balloon_cfg.tail_side         = RST_TAIL_SIDE;
		balloon_cfg.tail_frame_offset = RST_TAIL_FRAME_OFFSET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_special_shapes();
		test_tail_sides();
		test_random_balloons();
		test_extreme_registers();

		// drain, then let stray classes show up with the sink always ready
		settle();
		quiet = 1'b1;
		repeat (16) @(posedge clk);
		if (pending_classes.size() != 0) begin
			$display("%0t: classes never returned, expected 0 owed, actual %0d",
				$time, pending_classes.size());
			errors++;
		end
		if (errors == 0)
			$display("balloon_shape_point_classifier test passed");
		else
			$display("balloon_shape_point_classifier test failed");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("balloon_shape_point_classifier test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bsp_pkg.sv
rtl/bsp_front.sv
rtl/balloon_shape_point_classifier.sv
test/tb_balloon_shape_point_classifier.sv
